/* hdl/dcf_pkg.sv */
// Shared types and constants of the decimal ASCII formatter.
// No dependencies; every other file of the block refers to this package by scoped names.
package dcf_pkg;

   localparam int ValueWidth    = 32;
   localparam int DigitCount    = 10;
   localparam int DigitWidth    = 4;
   localparam int CharWidth     = 8;
   localparam int HalfWidth     = 16;
   localparam int CmdWidth      = 2;
   localparam int CsrIndexWidth = 1;
   localparam int IdxWidth      = $clog2(DigitCount);
   localparam int StepCntWidth  = $clog2(ValueWidth);

   localparam logic [ValueWidth-1:0] SentinelReset    = 32'd9999;
   localparam logic [ValueWidth-1:0] ReplacementReset = 32'd65535;

   localparam logic [CharWidth-1:0] CharZero  = 8'h30;
   localparam logic [CharWidth-1:0] CharNine  = 8'h39;
   localparam logic [CharWidth-1:0] CharMinus = 8'h2D;
   localparam logic [CharWidth-1:0] CharPoint = 8'h2E;

   // Digit index of the units of the integer part in fixed-point mode.
   localparam logic [IdxWidth-1:0] PointUnitsIdx = 4'd2;
   localparam logic [IdxWidth-1:0] PointTenthsIdx = 4'd1;

   typedef enum logic [CmdWidth-1:0] {
      CmdUnsigned = 2'd0,
      CmdSigned   = 2'd1,
      CmdPoint    = 2'd2,
      CmdNone     = 2'd3
   } command_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CsrSentinel    = 1'b0,
      CsrReplacement = 1'b1
   } csr_index_type;

   typedef logic [DigitCount-1:0][DigitWidth-1:0] bcd_type;

   // Start of one item, issued at the accepting edge.
   typedef struct packed {
      logic                  start;
      logic                  neg;
      logic                  point;
      logic [ValueWidth-1:0] operand;
   } start_type;

   // Result of the binary to BCD conversion.
   typedef struct packed {
      logic    done;
      bcd_type bcd;
   } conv_type;

endpackage

/* hdl/decimal_ascii_formatter.sv */
// Decimal ASCII formatter, top level: request intake, settings registers, operand selection.
// Depends on dcf_pkg, dcf_bcd_conv and dcf_emitter.
//
// Usage:
//   Request channel (req_valid, req_stall, req_command, req_value): one item is a
//   mode and a number. Unsigned mode prints all 32 bits, signed mode prints the low
//   16 bits as two's complement with a leading minus, fixed-point mode prints the low
//   16 bits as hundredths ("123.45"). Command 3 is taken and produces nothing.
//   Response channel (rsp_valid, rsp_stall, rsp_ascii_char, rsp_last): one item per
//   character, most significant first, rsp_last set on the final one.
//   Settings port (csr_write_en, csr_index, csr_write_data): index 0 is the sentinel,
//   index 1 its replacement; write only while the block is idle.
// Timing: the number is converted to BCD one bit per cycle, then the first character
//   appears and the rest follow one per cycle while the response is not stalled;
//   req_stall stays high until the last character is loaded into the response
//   register, so the next item overlaps its delivery.
// A stalled response holds its character; the sequencer waits with it.
// Reset (synchronous) empties the response register, returns to idle and restores
//   sentinel 9999 and replacement 65535.
module decimal_ascii_formatter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dcf_pkg::CmdWidth-1:0]        req_command,
   input  logic [dcf_pkg::ValueWidth-1:0]      req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dcf_pkg::CharWidth-1:0]       rsp_ascii_char,
   output logic                                rsp_last,
   input  logic                                csr_write_en,
   input  logic [dcf_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [dcf_pkg::ValueWidth-1:0]      csr_write_data
);

   logic [dcf_pkg::ValueWidth-1:0] sentinel_ff, sentinel_in;
   logic [dcf_pkg::ValueWidth-1:0] replacement_ff, replacement_in;
   logic [dcf_pkg::HalfWidth-1:0]  low16;
   logic [dcf_pkg::HalfWidth-1:0]  magnitude;
   logic [dcf_pkg::ValueWidth-1:0] sub_src;
   logic [dcf_pkg::ValueWidth-1:0] sub_val;
   logic                           emit_idle;
   logic                           accept;
   dcf_pkg::command_type           cmd;
   dcf_pkg::start_type             start;
   dcf_pkg::conv_type              conv;

   always_comb begin
      sentinel_in    = sentinel_ff;
      replacement_in = replacement_ff;
      if (csr_write_en) begin
         case (dcf_pkg::csr_index_type'(csr_index))
            dcf_pkg::CsrSentinel:    sentinel_in    = csr_write_data;
            dcf_pkg::CsrReplacement: replacement_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sentinel_ff    <= dcf_pkg::SentinelReset;
         replacement_ff <= dcf_pkg::ReplacementReset;
      end else begin
         sentinel_ff    <= sentinel_in;
         replacement_ff <= replacement_in;
      end
   end

   assign req_stall = !emit_idle;
   assign accept    = req_valid && !req_stall;
   assign cmd       = dcf_pkg::command_type'(req_command);
   assign low16     = req_value[dcf_pkg::HalfWidth-1:0];
   assign magnitude = ~low16 + 16'd1;
   assign sub_src   = (cmd == dcf_pkg::CmdUnsigned) ? req_value : {16'b0, low16};
   assign sub_val   = (sub_src == sentinel_ff) ? replacement_ff : sub_src;

   always_comb begin
      start.start   = accept && (cmd != dcf_pkg::CmdNone);
      start.neg     = (cmd == dcf_pkg::CmdSigned) && low16[dcf_pkg::HalfWidth-1];
      start.point   = (cmd == dcf_pkg::CmdPoint);
      start.operand = sub_val;
      case (cmd)
         dcf_pkg::CmdSigned: begin
            if (low16[dcf_pkg::HalfWidth-1]) begin
               start.operand = {16'b0, magnitude};
            end
         end
         dcf_pkg::CmdPoint: start.operand = {16'b0, low16};
         default: ;
      endcase
   end

   dcf_bcd_conv u_conv (
      .clock (clock),
      .reset (reset),
      .start (start),
      .conv  (conv)
   );

   dcf_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .conv           (conv),
      .idle           (emit_idle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

endmodule

/* hdl/dcf_bcd_conv.sv */
// Bit-serial binary to BCD converter (shift and add-three), one input bit per cycle.
// Depends on dcf_pkg.
module dcf_bcd_conv (
   input  logic               clock,
   input  logic               reset,
   input  dcf_pkg::start_type start,
   output dcf_pkg::conv_type  conv
);

   logic [dcf_pkg::ValueWidth-1:0]   bin_ff, bin_in;
   dcf_pkg::bcd_type                 bcd_ff, bcd_in;
   logic [dcf_pkg::StepCntWidth-1:0] cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   dcf_pkg::bcd_type                 adj;
   logic [dcf_pkg::DigitCount*dcf_pkg::DigitWidth:0] shifted;

   always_comb begin
      for (int i = 0; i < dcf_pkg::DigitCount; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   // The top digit never reaches eight, so the bit shifted out is always zero.
   assign shifted = {adj, bin_ff[dcf_pkg::ValueWidth-1]};

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start.start) begin
         bin_in  = start.operand;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = shifted[dcf_pkg::DigitCount*dcf_pkg::DigitWidth-1:0];
         bin_in = {bin_ff[dcf_pkg::ValueWidth-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (&cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign conv.done = done_ff;
   assign conv.bcd  = bcd_ff;

endmodule

/* hdl/dcf_emitter.sv */
// Character sequencer: walks the BCD digits and drives the registered result channel.
// Depends on dcf_pkg; takes its digits from dcf_bcd_conv.
module dcf_emitter (
   input  logic                            clock,
   input  logic                            reset,
   input  dcf_pkg::start_type              start,
   input  dcf_pkg::conv_type               conv,
   output logic                            idle,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dcf_pkg::CharWidth-1:0]   rsp_ascii_char,
   output logic                            rsp_last
);

   typedef enum logic [1:0] {
      IDLE,
      WAIT,
      SIGN,
      DIGIT
   } state_type;

   state_type                        state_ff, state_in;
   logic                             neg_ff, neg_in;
   logic                             point_ff, point_in;
   logic                             dot_pend_ff, dot_pend_in;
   logic [dcf_pkg::IdxWidth-1:0]     idx_ff, idx_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [dcf_pkg::CharWidth-1:0]    rsp_char_ff, rsp_char_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic [dcf_pkg::IdxWidth-1:0]     first_idx;
   logic                             can_load;

   // Highest nonzero digit; fixed point always shows its units digit.
   always_comb begin
      first_idx = '0;
      for (int i = 1; i < dcf_pkg::DigitCount; i++) begin
         if (conv.bcd[i] != '0) begin
            first_idx = dcf_pkg::IdxWidth'(i);
         end
      end
      if (point_ff && first_idx < dcf_pkg::PointUnitsIdx) begin
         first_idx = dcf_pkg::PointUnitsIdx;
      end
   end

   assign can_load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      point_in     = point_ff;
      dot_pend_in  = dot_pend_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         IDLE: begin
            if (start.start) begin
               neg_in   = start.neg;
               point_in = start.point;
               state_in = WAIT;
            end
         end
         WAIT: begin
            if (conv.done) begin
               idx_in      = first_idx;
               dot_pend_in = point_ff;
               state_in    = neg_ff ? SIGN : DIGIT;
            end
         end
         SIGN: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = dcf_pkg::CharMinus;
               rsp_last_in  = 1'b0;
               state_in     = DIGIT;
            end
         end
         DIGIT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               if (dot_pend_ff && idx_ff == dcf_pkg::PointTenthsIdx) begin
                  rsp_char_in = dcf_pkg::CharPoint;
                  rsp_last_in = 1'b0;
                  dot_pend_in = 1'b0;
               end else begin
                  rsp_char_in = dcf_pkg::CharZero + {4'b0, conv.bcd[idx_ff]};
                  rsp_last_in = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = IDLE;
                  end else begin
                     idx_in = idx_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         dot_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dot_pend_ff  <= dot_pend_in;
      end
      neg_ff      <= neg_in;
      point_ff    <= point_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign idle           = (state_ff == IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

/* hdl/dcf_checker.sv */
// Port-level checks of the decimal ASCII formatter, attached to the top level by bind.
// Depends on dcf_pkg and decimal_ascii_formatter.
module dcf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [dcf_pkg::CmdWidth-1:0]      req_command,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [dcf_pkg::CharWidth-1:0]     rsp_ascii_char,
   input logic                              rsp_last
);

   // A held response keeps its character and flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ascii_char) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // An item that prints something keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_command != dcf_pkg::CmdNone) |=> req_stall)
      else $error("request taken again without conversion");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ascii_char >= dcf_pkg::CharZero && rsp_ascii_char <= dcf_pkg::CharNine)
                    || rsp_ascii_char == dcf_pkg::CharMinus
                    || rsp_ascii_char == dcf_pkg::CharPoint)
      else $error("response character outside digit, minus and point");

   // Text always ends in a digit.
   a_last_is_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_ascii_char == dcf_pkg::CharMinus
                    || rsp_ascii_char == dcf_pkg::CharPoint) |-> !rsp_last)
      else $error("sign or point flagged as last character");

endmodule

bind decimal_ascii_formatter dcf_checker u_dcf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_command    (req_command),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_ascii_char (rsp_ascii_char),
   .rsp_last       (rsp_last)
);

/* tb/tb_top.sv */
// Self-checking testbench for decimal_ascii_formatter: directed and random items, checked
// character by character against a predictor kept in this file.
// Depends on dcf_pkg and the decimal_ascii_formatter RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int HalfPeriod   = 4;
   localparam int MaxWait      = 12;
   localparam int SettleCycles = 64;
   localparam int HoldCycles   = 600;
   localparam int CycleLimit   = 400000;
   localparam int PrintLimit   = 40;
   localparam int PhaseItems   = 60;

   typedef struct packed {
      logic [dcf_pkg::CharWidth-1:0] ch;
      logic                          last;
   } text_char_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [dcf_pkg::CmdWidth-1:0]      req_command = dcf_pkg::CmdUnsigned;
   logic [dcf_pkg::ValueWidth-1:0]    req_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [dcf_pkg::CharWidth-1:0]     rsp_ascii_char;
   logic                              rsp_last;
   logic                              csr_write_en = 1'b0;
   logic [dcf_pkg::CsrIndexWidth-1:0] csr_index = dcf_pkg::CsrSentinel;
   logic [dcf_pkg::ValueWidth-1:0]    csr_write_data = '0;

   // Copy of the settings registers as the predictor sees them.
   logic [dcf_pkg::ValueWidth-1:0] cfg_sentinel = dcf_pkg::SentinelReset;
   logic [dcf_pkg::ValueWidth-1:0] cfg_replacement = dcf_pkg::ReplacementReset;

   logic [dcf_pkg::CharWidth-1:0] line_chars[$];
   text_char_type                 expected_text[$];
   int                            mismatches = 0;
   int                            cycle_count = 0;
   bit                            quiet = 1'b0;
   bit                            rsp_hold_req = 1'b0;

   decimal_ascii_formatter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #(HalfPeriod) clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [dcf_pkg::ValueWidth-1:0] swap_sentinel(
         logic [dcf_pkg::ValueWidth-1:0] v);
      return (v == cfg_sentinel) ? cfg_replacement : v;
   endfunction

   // Appends the decimal digits of v, most significant first, without leading zeros.
   function automatic void emit_decimal(logic [dcf_pkg::ValueWidth-1:0] v);
      logic [dcf_pkg::CharWidth-1:0] digit[dcf_pkg::DigitCount];
      int                            count;
      count = 1;
      for (int i = 0; i < dcf_pkg::DigitCount; i++) begin
         digit[i] = dcf_pkg::CharZero + dcf_pkg::CharWidth'(v % 10);
         v = v / 10;
         if (v != 0) count = i + 2;
      end
      for (int i = count - 1; i >= 0; i--) line_chars.push_back(digit[i]);
   endfunction

   function automatic void predict_text(dcf_pkg::command_type cmd,
                                        logic [dcf_pkg::ValueWidth-1:0] val);
      logic [dcf_pkg::HalfWidth-1:0]  half;
      logic [dcf_pkg::ValueWidth-1:0] frac;
      text_char_type                  e;
      half = val[dcf_pkg::HalfWidth-1:0];
      line_chars.delete();
      case (cmd)
         dcf_pkg::CmdUnsigned: emit_decimal(swap_sentinel(val));
         dcf_pkg::CmdSigned: begin
            if (half[dcf_pkg::HalfWidth-1]) begin
               line_chars.push_back(dcf_pkg::CharMinus);
               emit_decimal(32'h0001_0000 - {16'h0000, half});
            end else begin
               // The 16-bit value is compared with the whole 32-bit sentinel.
               emit_decimal(swap_sentinel({16'h0000, half}));
            end
         end
         dcf_pkg::CmdPoint: begin
            frac = half % 100;
            emit_decimal(half / 100);
            line_chars.push_back(dcf_pkg::CharPoint);
            line_chars.push_back(dcf_pkg::CharZero + dcf_pkg::CharWidth'(frac / 10));
            line_chars.push_back(dcf_pkg::CharZero + dcf_pkg::CharWidth'(frac % 10));
         end
         default: ;
      endcase
      for (int k = 0; k < line_chars.size(); k++) begin
         e.ch   = line_chars[k];
         e.last = (k == line_chars.size() - 1);
         expected_text.push_back(e);
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < PrintLimit)
         $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic int rand_gap();
      return quiet ? 0 : $urandom_range(0, MaxWait);
   endfunction

   task automatic send_item(dcf_pkg::command_type cmd, logic [dcf_pkg::ValueWidth-1:0] val,
                            int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_value   <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_text(cmd, val);
   endtask

   // Stops offering items until every expected character is in, then waits for
   // the block to settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic set_config(logic [dcf_pkg::ValueWidth-1:0] sentinel,
                             logic [dcf_pkg::ValueWidth-1:0] repl);
      csr_write_en   <= 1'b1;
      csr_index      <= dcf_pkg::CsrSentinel;
      csr_write_data <= sentinel;
      @(posedge clock);
      csr_index      <= dcf_pkg::CsrReplacement;
      csr_write_data <= repl;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_sentinel    = sentinel;
      cfg_replacement = repl;
   endtask

   function automatic dcf_pkg::command_type rand_command();
      int r;
      r = $urandom_range(0, 15);
      if (r < 5) return dcf_pkg::CmdUnsigned;
      if (r < 10) return dcf_pkg::CmdSigned;
      if (r < 15) return dcf_pkg::CmdPoint;
      return dcf_pkg::CmdNone;
   endfunction

   function automatic logic [dcf_pkg::ValueWidth-1:0] rand_value();
      logic [dcf_pkg::ValueWidth-1:0] v;
      logic [dcf_pkg::ValueWidth-1:0] r;
      logic [dcf_pkg::ValueWidth-1:0] p;
      r = $urandom;
      p = 1;
      repeat ($urandom_range(1, 9)) p = p * 10;
      case ($urandom_range(0, 5))
         0: v = r;
         1: v = $urandom_range(0, 99);
         2: v = $urandom_range(0, 1) ? cfg_sentinel : {r[31:16], cfg_sentinel[15:0]};
         3: v = r % p;
         4: v = $urandom_range(0, 1) ? p : p - 1;
         default: v = {r[31:16], ($urandom_range(0, 1) ? 16'h8000 : 16'hFFFF)};
      endcase
      return v;
   endfunction

   // ---------------------------------------------------------------- receiver

   initial begin : rsp_side
      int wait_cycles;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_stall <= 1'b1;
            for (int c = 0; c < HoldCycles; c++) @(posedge clock);
            rsp_hold_req = 1'b0;
         end
         wait_cycles = rand_gap();
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : check_text
      text_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_text.size() == 0) begin
            report_mismatch("unexpected character", 32'(rsp_ascii_char), 32'd0);
         end else begin
            want = expected_text.pop_front();
            if (rsp_ascii_char !== want.ch)
               report_mismatch("ascii_char", 32'(rsp_ascii_char), 32'(want.ch));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("decimal_ascii_formatter: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_reset_defaults();
      send_item(dcf_pkg::CmdUnsigned, 32'd0, rand_gap());
      send_item(dcf_pkg::CmdUnsigned, 32'hFFFF_FFFF, rand_gap());
      send_item(dcf_pkg::CmdUnsigned, 32'd9999, rand_gap());
      send_item(dcf_pkg::CmdUnsigned, 32'd1000000000, rand_gap());
      send_item(dcf_pkg::CmdUnsigned, 32'd999999999, rand_gap());
      send_item(dcf_pkg::CmdSigned, 32'h0000_8000, rand_gap());
      send_item(dcf_pkg::CmdSigned, 32'h0000_7FFF, rand_gap());
      send_item(dcf_pkg::CmdSigned, 32'hFFFF_FFFF, rand_gap());
      send_item(dcf_pkg::CmdSigned, 32'hFFFF_0000, rand_gap());
      send_item(dcf_pkg::CmdSigned, 32'hABCD_270F, rand_gap());
      send_item(dcf_pkg::CmdPoint, 32'd0, rand_gap());
      send_item(dcf_pkg::CmdPoint, 32'd7, rand_gap());
      send_item(dcf_pkg::CmdPoint, 32'd12345, rand_gap());
      send_item(dcf_pkg::CmdPoint, 32'hFFFF_FFFF, rand_gap());
      send_item(dcf_pkg::CmdPoint, 32'd9999, 0);
      send_item(dcf_pkg::CmdNone, 32'hFFFF_FFFF, 0);
      send_item(dcf_pkg::CmdUnsigned, 32'd10, rand_gap());
   endtask

   task automatic test_config_extremes();
      wait_idle();
      set_config(32'd0, 32'hFFFF_FFFF);
      send_item(dcf_pkg::CmdUnsigned, 32'd0, rand_gap());
      send_item(dcf_pkg::CmdSigned, 32'h5555_0000, rand_gap());
      send_item(dcf_pkg::CmdPoint, 32'd0, rand_gap());
      wait_idle();
      set_config(32'hFFFF_FFFF, 32'd0);
      send_item(dcf_pkg::CmdUnsigned, 32'hFFFF_FFFF, rand_gap());
      send_item(dcf_pkg::CmdSigned, 32'h0000_FFFF, rand_gap());
   endtask

   // The signed check uses all 32 sentinel bits, so upper bits must match zero.
   task automatic test_signed_sentinel_width();
      wait_idle();
      set_config(32'h0001_1234, 32'd42);
      send_item(dcf_pkg::CmdSigned, 32'h0000_1234, rand_gap());
      send_item(dcf_pkg::CmdUnsigned, 32'h0001_1234, rand_gap());
      wait_idle();
      set_config(32'h0000_1234, 32'd4294967295);
      send_item(dcf_pkg::CmdSigned, 32'hFFFF_1234, rand_gap());
      send_item(dcf_pkg::CmdUnsigned, 32'h0000_1234, rand_gap());
   endtask

   // The receiver holds off for a long stretch while items keep coming.
   task automatic test_backpressure();
      wait_idle();
      rsp_hold_req = 1'b1;
      repeat (12) send_item(rand_command(), rand_value(), 0);
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: set_config($urandom_range(0, 99999), $urandom);
            1: set_config($urandom_range(0, 32767), $urandom);
            2: set_config($urandom, $urandom);
            default: set_config(dcf_pkg::SentinelReset, dcf_pkg::ReplacementReset);
         endcase
         for (int n = 0; n < PhaseItems; n++) begin
            if (n % 15 == 0) quiet = ($urandom_range(0, 3) == 0);
            send_item(rand_command(), rand_value(), rand_gap());
         end
         quiet = 1'b0;
      end
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_config_extremes();
      test_signed_sentinel_width();
      test_backpressure();
      test_random_phases();
      wait_idle();
      if (mismatches == 0) begin
         $display("decimal_ascii_formatter: match");
      end else begin
         $display("decimal_ascii_formatter: mismatch");
      end
      $finish;
   end

endmodule

/* decimal_ascii_formatter.f */
hdl/dcf_pkg.sv
hdl/dcf_bcd_conv.sv
hdl/dcf_emitter.sv
hdl/decimal_ascii_formatter.sv
hdl/dcf_checker.sv
tb/tb_top.sv
